FILE: rtl/spd_pkg.sv
// Package for the spike peak detector: sizes, register indexes, reset values,
// the structs passed between the top level, the lanes and the merging stage.
// No dependencies.
package spd_pkg;

	localparam int NUM_LANES   = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int INDEX_BITS  = 32;

	localparam int VAL_BITS    = SAMPLE_BITS + 1;
	localparam int CMPV_BITS   = (VAL_BITS > 17) ? VAL_BITS : 17;
	localparam int TIME_BITS   = 32;
	localparam int CMP_BITS    = ((INDEX_BITS > TIME_BITS) ? INDEX_BITS : TIME_BITS) + 1;
	localparam int CH_BITS     = 3;
	localparam int USED_BITS   = 4;
	localparam int THR_BITS    = 16;
	localparam int INT_BITS    = 16;
	localparam int CLIP_BITS   = 8;
	localparam int MARGIN_BITS = 7;
	localparam int REC_BITS    = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int NUM_SLOTS   = 2 * NUM_LANES;
	localparam int SLOT_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_POLARITY   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_USED       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP       = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECORD     = 3'd6;

	// Polarity codes.
	localparam logic [1:0] POL_KEEP   = 2'd0;
	localparam logic [1:0] POL_NEGATE = 2'd1;
	localparam logic [1:0] POL_ABS    = 2'd2;

	// Register reset values.
	localparam logic [1:0]           RST_POLARITY  = POL_KEEP;
	localparam logic [USED_BITS-1:0] RST_USED      = 4'd8;
	localparam logic [THR_BITS-1:0]  RST_THRESHOLD = 16'd1000;
	localparam logic [INT_BITS-1:0]  RST_INTERVAL  = 16'd10;
	localparam logic [CLIP_BITS-1:0] RST_CLIP      = 8'd50;
	localparam logic [REC_BITS-1:0]  RST_RECORD    = 32'hFFFF_FFFF;

	typedef logic signed [VAL_BITS-1:0] val_t;
	typedef logic [INDEX_BITS-1:0] index_t;

	typedef struct packed {
		logic [THR_BITS-1:0]    threshold;
		logic [INT_BITS-1:0]    interval;
		logic [MARGIN_BITS-1:0] margin;
		logic [REC_BITS-1:0]    record_length;
	} lane_cfg_t;

	typedef struct packed {
		logic adv;
		logic active;
		logic eor;
	} lane_ctrl_t;

	typedef struct packed {
		logic   det_v;
		index_t det_t;
		logic   fl_v;
		index_t fl_t;
		logic   pend;
	} lane_evt_t;

	// True when a peak at time t lies clear of both record edges.
	function automatic logic in_margins(input index_t t, input logic [MARGIN_BITS-1:0] m,
			input logic [REC_BITS-1:0] rec);
		logic [CMP_BITS-1:0] sum;
		sum = CMP_BITS'(t) + CMP_BITS'(m);
		return (CMP_BITS'(t) >= CMP_BITS'(m)) && (sum < CMP_BITS'(rec));
	endfunction

endpackage

FILE: rtl/spd_lane.sv
// One detector lane: pending peak state, refractory check and flush.
// Depends on spd_pkg.
module spd_lane import spd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  lane_cfg_t  cfg,
	input  val_t       v,
	input  index_t     t,
	output lane_evt_t  evt
);

	logic   pend_q;
	index_t idx_q;
	val_t   val_q;

	index_t diff;
	logic   lapse;
	logic   cand;
	logic   pos;
	logic   pend_n;
	index_t idx_n;
	val_t   val_n;

	always_comb begin
		diff   = t - idx_q;
		lapse  = pend_q && (diff > INDEX_BITS'(cfg.interval));
		cand   = signed'(CMPV_BITS'(v)) >= signed'(CMPV_BITS'({1'b0, cfg.threshold}));
		pos    = !val_q[VAL_BITS-1] && (val_q != '0);
		pend_n = pend_q;
		idx_n  = idx_q;
		val_n  = val_q;
		if (ctrl.active) begin
			if (lapse)
				pend_n = 1'b0;
			if (cand) begin
				if (pend_n && pos) begin
					if (v > val_q) begin
						idx_n = t;
						val_n = v;
					end
				end else begin
					pend_n = 1'b1;
					idx_n  = t;
					val_n  = v;
				end
			end
		end
		// A peak of value zero cannot be replaced, so a new candidate pushes it out.
		evt.det_v = ctrl.active && pend_q && (lapse || (cand && !pos)) &&
			in_margins(idx_q, cfg.margin, cfg.record_length);
		evt.det_t = idx_q;
		evt.fl_v  = ctrl.eor && pend_n && in_margins(idx_n, cfg.margin, cfg.record_length);
		evt.fl_t  = idx_n;
		evt.pend  = pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ctrl.adv) begin
			pend_q <= pend_n && !ctrl.eor;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			idx_q <= idx_n;
			val_q <= val_n;
		end
	end

endmodule

FILE: rtl/spd_merge.sv
// Merging stage: holds the events of one timepoint and hands them out one per
// cycle unless stalled, lowest slot first, through the output register. Depends on spd_pkg.
module spd_merge import spd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  lane_evt_t            lane_evt [NUM_LANES],
	input  logic                 per_channel,
	output logic                 free,
	output logic                 event_valid,
	input  logic                 event_stall,
	output logic [TIME_BITS-1:0] event_time,
	output logic [CH_BITS-1:0]   event_channel,
	output logic                 last_of_run
);

	logic [NUM_SLOTS-1:0] mask_q;
	index_t               time_q [NUM_SLOTS];
	logic                 out_valid_q;

	logic [SLOT_BITS-1:0] sel;
	logic [NUM_SLOTS-1:0] remaining;
	logic                 out_load;
	logic                 pop;
	logic [NUM_SLOTS-1:0] new_mask;

	always_comb begin
		sel = '0;
		for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
			if (mask_q[k])
				sel = SLOT_BITS'(k);
		end
		remaining = mask_q;
		remaining[sel] = 1'b0;
		out_load = !out_valid_q || !event_stall;
		pop      = out_load && (mask_q != '0);
		free     = (mask_q == '0) || (pop && (remaining == '0));
		for (int m = 0; m < NUM_LANES; m++) begin
			new_mask[m]             = lane_evt[m].det_v;
			new_mask[m + NUM_LANES] = lane_evt[m].fl_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				mask_q <= new_mask;
			else if (pop)
				mask_q <= remaining;
			if (out_load)
				out_valid_q <= (mask_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int m = 0; m < NUM_LANES; m++) begin
				time_q[m]             <= lane_evt[m].det_t;
				time_q[m + NUM_LANES] <= lane_evt[m].fl_t;
			end
		end
		if (pop) begin
			event_time    <= TIME_BITS'(time_q[sel]);
			event_channel <= per_channel ? CH_BITS'(sel % NUM_LANES) : '0;
			last_of_run   <= (remaining == '0);
		end
	end

	assign event_valid = out_valid_q;

endmodule

FILE: rtl/spike_peak_detector.sv
// Top level of the spike peak detector: configuration registers, rectifying
// input stage, detector lanes and the merging stage. Depends on spd_pkg,
// spd_lane and spd_merge.
//
//   Channel   Handshake                     Payload
//   --------  ----------------------------  ---------------------------------------
//   samples   sample_valid / sample_stall   sample_0..sample_7, end_of_record
//   events    event_valid / event_stall     event_time, event_channel, last_of_run
//   config    cfg_we                        cfg_index, cfg_data
//
// A timepoint is taken every cycle while sample_stall is low. It is rectified in
// the first stage, the lanes update their pending peaks in the second, and the
// merging stage then sends out its events one per cycle while event_stall is low,
// through the single output register, taking the next timepoint only once it is
// empty or is sending its last event. Reset sets the configuration registers to
// their reset values and clears the counter and every pending flag at once;
// there is no clearing pass. A stall on the event side backs up into sample_stall
// only once the rectifying stage and the merger both hold work.
module spike_peak_detector import spd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_3,
	input  logic signed [SAMPLE_BITS-1:0] sample_4,
	input  logic signed [SAMPLE_BITS-1:0] sample_5,
	input  logic signed [SAMPLE_BITS-1:0] sample_6,
	input  logic signed [SAMPLE_BITS-1:0] sample_7,
	input  logic                          end_of_record,
	output logic                          event_valid,
	input  logic                          event_stall,
	output logic [TIME_BITS-1:0]          event_time,
	output logic [CH_BITS-1:0]            event_channel,
	output logic                          last_of_run
);

	// Configuration registers.
	logic [1:0]           polarity_q;
	logic                 mode_q;
	logic [USED_BITS-1:0] used_q;
	logic [THR_BITS-1:0]  threshold_q;
	logic [INT_BITS-1:0]  interval_q;
	logic [CLIP_BITS-1:0] clip_q;
	logic [REC_BITS-1:0]  record_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q  <= RST_POLARITY;
			mode_q      <= 1'b0;
			used_q      <= RST_USED;
			threshold_q <= RST_THRESHOLD;
			interval_q  <= RST_INTERVAL;
			clip_q      <= RST_CLIP;
			record_q    <= RST_RECORD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLARITY:  polarity_q  <= cfg_data[1:0];
				REG_MODE:      mode_q      <= cfg_data[0];
				REG_USED:      used_q      <= cfg_data[USED_BITS-1:0];
				REG_THRESHOLD: threshold_q <= cfg_data[THR_BITS-1:0];
				REG_INTERVAL:  interval_q  <= cfg_data[INT_BITS-1:0];
				REG_CLIP:      clip_q      <= cfg_data[CLIP_BITS-1:0];
				REG_RECORD:    record_q    <= cfg_data[REC_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Lanes in use, held to the range one to NUM_LANES.
	logic [USED_BITS-1:0]   used_lanes;
	logic [CLIP_BITS:0]     clip_half;
	logic [MARGIN_BITS-1:0] margin;
	lane_cfg_t              lane_cfg;

	always_comb begin
		if (used_q == '0)
			used_lanes = USED_BITS'(1);
		else if (used_q > USED_BITS'(NUM_LANES))
			used_lanes = USED_BITS'(NUM_LANES);
		else
			used_lanes = used_q;
		// The edge margin is half the clip, rounded up, less one; no margin for an empty clip.
		clip_half = ({1'b0, clip_q} + (CLIP_BITS+1)'(1)) >> 1;
		margin    = (clip_q == '0) ? '0 : MARGIN_BITS'(clip_half - (CLIP_BITS+1)'(1));
		lane_cfg.threshold     = threshold_q;
		lane_cfg.interval      = interval_q;
		lane_cfg.margin        = margin;
		lane_cfg.record_length = record_q;
	end

	function automatic val_t rectify(input logic signed [SAMPLE_BITS-1:0] x,
			input logic [1:0] pol);
		val_t xe;
		xe = VAL_BITS'(x);
		case (pol)
			POL_KEEP:   return xe;
			POL_NEGATE: return -xe;
			default:    return xe[VAL_BITS-1] ? -xe : xe;
		endcase
	endfunction

	// First stage: rectify every lane and, in combined mode, take the largest
	// rectified value over the lanes in use (never below zero) into lane 0.
	logic signed [SAMPLE_BITS-1:0] samples [8];
	val_t rect [NUM_LANES];
	val_t best;

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;
	assign samples[6] = sample_6;
	assign samples[7] = sample_7;

	always_comb begin
		best = '0;
		for (int m = 0; m < NUM_LANES; m++) begin
			rect[m] = rectify(samples[m], polarity_q);
			if ((USED_BITS'(m) < used_lanes) && (rect[m] > best))
				best = rect[m];
		end
	end

	logic valid_s1;
	logic eor_s1;
	val_t val_s1 [NUM_LANES];
	logic merge_free;
	logic det_adv;
	logic s1_load;

	assign det_adv      = valid_s1 && merge_free;
	assign s1_load      = !valid_s1 || det_adv;
	assign sample_stall = !s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && sample_valid) begin
			eor_s1    <= end_of_record;
			val_s1[0] <= mode_q ? rect[0] : best;
			for (int m = 1; m < NUM_LANES; m++)
				val_s1[m] <= rect[m];
		end
	end

	// Second stage: the sample counter and the detector lanes.
	index_t counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (det_adv) begin
			counter_q <= eor_s1 ? '0 : counter_q + INDEX_BITS'(1);
		end
	end

	lane_ctrl_t lane_ctrl [NUM_LANES];
	lane_evt_t  lane_evt  [NUM_LANES];

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		// Combined mode runs only the lane 0 detector; the others keep their
		// pending peaks until a later timepoint uses them or a flush sends them.
		assign lane_ctrl[g].adv    = det_adv;
		assign lane_ctrl[g].active = mode_q ? (USED_BITS'(g) < used_lanes) : (g == 0);
		assign lane_ctrl[g].eor    = eor_s1;

		spd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl[g]),
			.cfg    (lane_cfg),
			.v      (val_s1[g]),
			.t      (counter_q),
			.evt    (lane_evt[g])
		);
	end

	spd_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (det_adv),
		.lane_evt      (lane_evt),
		.per_channel   (mode_q),
		.free          (merge_free),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_time    (event_time),
		.event_channel (event_channel),
		.last_of_run   (last_of_run)
	);

	logic [NUM_LANES-1:0] pend_all;

	always_comb begin
		for (int m = 0; m < NUM_LANES; m++)
			pend_all[m] = lane_evt[m].pend;
	end

`ifndef ASSERT_OFF
	a_counter_restart: assert property (@(posedge clk) disable iff (!arst_n)
		det_adv && eor_s1 |=> counter_q == '0)
		else $error("sample counter did not restart after end of record");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		det_adv && !eor_s1 |=> counter_q == $past(counter_q) + INDEX_BITS'(1))
		else $error("sample counter did not advance by one");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		det_adv && eor_s1 |=> pend_all == '0)
		else $error("a peak stayed pending after end of record");

	a_stall_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && !merge_free)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

FILE: verif/tb_spike_peak_detector.sv
// Self-checking testbench for spike_peak_detector: directed and random timepoints
// are predicted by a behavioural model held here and compared event by event.
// Depends on spd_pkg and the spike_peak_detector RTL.
module tb_spike_peak_detector;
	timeunit 1ns;
	timeprecision 1ps;
	import spd_pkg::*;

	localparam int SETTLE_CYCLES     = 16;
	localparam int RANDOM_ITEMS      = 80;
	localparam int CYCLE_LIMIT       = 600000;

	// Index 7 is not a register; a write there must change nothing.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;
	// The fourth polarity code behaves as absolute value.
	localparam logic [1:0] POL_ABS_ALT = 2'd3;

	typedef logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] timepoint_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] t;
		logic [CH_BITS-1:0]   ch;
		logic                 is_last;
	} peak_event_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [CFG_IDX_BITS-1:0]       cfg_index;
	logic [CFG_DATA_BITS-1:0]      cfg_data;
	logic                          sample_valid;
	logic                          sample_stall;
	logic signed [SAMPLE_BITS-1:0] sample_0, sample_1, sample_2, sample_3;
	logic signed [SAMPLE_BITS-1:0] sample_4, sample_5, sample_6, sample_7;
	logic                          end_of_record;
	logic                          event_valid;
	logic                          event_stall = 1'b0;
	logic [TIME_BITS-1:0]          event_time;
	logic [CH_BITS-1:0]            event_channel;
	logic                          last_of_run;

	spike_peak_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_0      (sample_0),
		.sample_1      (sample_1),
		.sample_2      (sample_2),
		.sample_3      (sample_3),
		.sample_4      (sample_4),
		.sample_5      (sample_5),
		.sample_6      (sample_6),
		.sample_7      (sample_7),
		.end_of_record (end_of_record),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_time    (event_time),
		.event_channel (event_channel),
		.last_of_run   (last_of_run)
	);

	always #2 clk = ~clk;

	// Shadow copy of the configuration registers, kept in step with every write.
	logic [1:0]            pol_cfg;
	logic                  per_lane;
	logic [USED_BITS-1:0]  lanes_cfg;
	logic [THR_BITS-1:0]   thr_cfg;
	logic [INT_BITS-1:0]   window_cfg;
	logic [CLIP_BITS-1:0]  clip_cfg;
	logic [REC_BITS-1:0]   rec_cfg;

	// Detector state: the timepoint counter and one held peak per lane.
	logic [INDEX_BITS-1:0] tp_index;
	logic                  peak_held [NUM_LANES];
	logic [INDEX_BITS-1:0] peak_at   [NUM_LANES];
	int                    peak_size [NUM_LANES];

	// Events predicted but not yet seen, oldest first, and the ones of the
	// timepoint being worked out.
	peak_event_t due_events[$];
	peak_event_t step_events[$];

	int failures       = 0;
	int events_checked = 0;
	int timepoints_sent = 0;
	int records_sent   = 0;
	int settings_used  = 0;
	int cycle_count    = 0;
	int stall_left     = 0;
	bit tx_gaps        = 1'b0;
	bit rx_stalls      = 1'b0;

	// ------------------------------------------------------------------
	// Detector model
	// ------------------------------------------------------------------

	function automatic int rectify(input logic [SAMPLE_BITS-1:0] raw);
		int x;
		x = $signed(raw);
		if (pol_cfg == POL_NEGATE)
			return -x;
		if ((pol_cfg == POL_ABS || pol_cfg == POL_ABS_ALT) && x < 0)
			return -x;
		return x;
	endfunction

	// A peak is only reported when a full clip around it fits in the record.
	function automatic void log_peak(input logic [INDEX_BITS-1:0] t,
			input logic [CH_BITS-1:0] ch);
		int margin;
		peak_event_t ev;
		margin = (clip_cfg == 0) ? 0 : (int'(clip_cfg) + 1) / 2 - 1;
		if ({2'b00, t} < 34'(margin) || {2'b00, t} + 34'(margin) >= {2'b00, rec_cfg})
			return;
		ev.t       = t;
		ev.ch      = ch;
		ev.is_last = 1'b0;
		step_events.push_back(ev);
	endfunction

	function automatic void update_detector(input int lane, input logic [CH_BITS-1:0] ch,
			input int v);
		logic [INDEX_BITS-1:0] age;
		int thr;
		age = tp_index - peak_at[lane];
		thr = thr_cfg;
		// A held peak whose window has run out goes first.
		if (peak_held[lane] && age > INDEX_BITS'(window_cfg)) begin
			log_peak(peak_at[lane], ch);
			peak_held[lane] = 1'b0;
		end
		if (v < thr)
			return;
		// Inside the window a strictly larger value takes over the held peak,
		// except that a peak of zero size can never be taken over.
		if (peak_held[lane] && peak_size[lane] > 0) begin
			if (v > peak_size[lane]) begin
				peak_at[lane]   = tp_index;
				peak_size[lane] = v;
			end
			return;
		end
		if (peak_held[lane])
			log_peak(peak_at[lane], ch);
		peak_held[lane] = 1'b1;
		peak_at[lane]   = tp_index;
		peak_size[lane] = v;
	endfunction

	function automatic void predict_timepoint(input timepoint_t tp, input logic eor);
		int lanes;
		int best;
		int r;
		peak_event_t ev;
		step_events.delete();
		lanes = (lanes_cfg == 0) ? 1 : (lanes_cfg > NUM_LANES) ? NUM_LANES : int'(lanes_cfg);
		if (per_lane) begin
			for (int i = 0; i < lanes; i++)
				update_detector(i, CH_BITS'(i), rectify(tp[i]));
		end else begin
			best = 0;
			for (int i = 0; i < lanes; i++) begin
				r = rectify(tp[i]);
				if (r > best)
					best = r;
			end
			update_detector(0, '0, best);
		end
		// End of record flushes every lane, in use or not.
		if (eor) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				if (peak_held[i]) begin
					log_peak(peak_at[i], per_lane ? CH_BITS'(i) : '0);
					peak_held[i] = 1'b0;
				end
			end
			tp_index = '0;
		end else begin
			tp_index = tp_index + 1'b1;
		end
		for (int i = 0; i < step_events.size(); i++) begin
			ev = step_events[i];
			ev.is_last = (i == step_events.size() - 1);
			due_events.push_back(ev);
		end
	endfunction

	function automatic void reset_model();
		pol_cfg    = RST_POLARITY;
		per_lane   = 1'b0;
		lanes_cfg  = RST_USED;
		thr_cfg    = RST_THRESHOLD;
		window_cfg = RST_INTERVAL;
		clip_cfg   = RST_CLIP;
		rec_cfg    = RST_RECORD;
		tp_index   = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			peak_held[i] = 1'b0;
			peak_at[i]   = '0;
			peak_size[i] = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Mostly short idle runs, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Background noise with spikes of either sign, a share of values right at
	// the threshold and a share of unrestricted codes.
	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		int r;
		int mag;
		r = $urandom_range(0, 99);
		if (r < 65)
			return SAMPLE_BITS'(int'($urandom_range(0, 400)) - 200);
		if (r < 85)
			mag = $urandom_range(500, 32767);
		else if (r < 92)
			mag = (thr_cfg > 32767) ? 32767 : int'(thr_cfg) - int'($urandom_range(0, 1));
		else
			return SAMPLE_BITS'($urandom);
		return $urandom_range(0, 1) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
	endfunction

	function automatic timepoint_t random_timepoint();
		timepoint_t tp;
		for (int k = 0; k < NUM_LANES; k++)
			tp[k] = random_sample();
		return tp;
	endfunction

	function automatic timepoint_t lanes_of(input int v0, input int v1, input int v2,
			input int v3, input int v4, input int v5, input int v6, input int v7);
		timepoint_t tp;
		tp[0] = SAMPLE_BITS'(v0);
		tp[1] = SAMPLE_BITS'(v1);
		tp[2] = SAMPLE_BITS'(v2);
		tp[3] = SAMPLE_BITS'(v3);
		tp[4] = SAMPLE_BITS'(v4);
		tp[5] = SAMPLE_BITS'(v5);
		tp[6] = SAMPLE_BITS'(v6);
		tp[7] = SAMPLE_BITS'(v7);
		return tp;
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Every task is entered and left just after a falling edge.
	// ------------------------------------------------------------------

	// Drops valid, lets every predicted event drain, then waits out the
	// pipeline so that timepoints without events are finished as well.
	task automatic await_idle();
		sample_valid <= 1'b0;
		while (due_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Bits above a register's width carry random junk, which must be ignored.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		logic [CFG_DATA_BITS-1:0] junk;
		logic [CFG_DATA_BITS-1:0] data;
		await_idle();
		junk = $urandom;
		data = value;
		case (idx)
		REG_POLARITY: begin
			data[31:2] = junk[31:2];
			pol_cfg = value[1:0];
		end
		REG_MODE: begin
			data[31:1] = junk[31:1];
			per_lane = value[0];
		end
		REG_USED: begin
			data[31:4] = junk[31:4];
			lanes_cfg = value[3:0];
		end
		REG_THRESHOLD: begin
			data[31:16] = junk[31:16];
			thr_cfg = value[15:0];
		end
		REG_INTERVAL: begin
			data[31:16] = junk[31:16];
			window_cfg = value[15:0];
		end
		REG_CLIP: begin
			data[31:8] = junk[31:8];
			clip_cfg = value[7:0];
		end
		REG_RECORD: begin
			rec_cfg = value;
		end
		default: begin
			data = junk;
		end
		endcase
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [1:0] pol, input logic mode,
			input logic [USED_BITS-1:0] lanes, input logic [THR_BITS-1:0] thr,
			input logic [INT_BITS-1:0] window, input logic [CLIP_BITS-1:0] clip,
			input logic [REC_BITS-1:0] rec);
		write_reg(REG_POLARITY, CFG_DATA_BITS'(pol));
		write_reg(REG_MODE, CFG_DATA_BITS'(mode));
		write_reg(REG_USED, CFG_DATA_BITS'(lanes));
		write_reg(REG_THRESHOLD, CFG_DATA_BITS'(thr));
		write_reg(REG_INTERVAL, CFG_DATA_BITS'(window));
		write_reg(REG_CLIP, CFG_DATA_BITS'(clip));
		write_reg(REG_RECORD, CFG_DATA_BITS'(rec));
		settings_used++;
	endtask

	// Presents one timepoint and holds it until the transaction completes; the
	// prediction is made at the accepting edge.
	task automatic send_timepoint(input timepoint_t tp, input logic eor);
		if (tx_gaps && $urandom_range(0, 99) < 40) begin
			sample_valid <= 1'b0;
			repeat (idle_length()) @(negedge clk);
		end
		sample_valid  <= 1'b1;
		sample_0      <= tp[0];
		sample_1      <= tp[1];
		sample_2      <= tp[2];
		sample_3      <= tp[3];
		sample_4      <= tp[4];
		sample_5      <= tp[5];
		sample_6      <= tp[6];
		sample_7      <= tp[7];
		end_of_record <= eor;
		do
			@(posedge clk);
		while (sample_stall);
		predict_timepoint(tp, eor);
		timepoints_sent++;
		if (eor)
			records_sent++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Event side: random stall runs, and the event checker.
	// ------------------------------------------------------------------

	always @(negedge clk) begin : stall_gen
		if (!rx_stalls) begin
			stall_left = 0;
			event_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			event_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < 25) begin
			stall_left = idle_length() - 1;
			event_stall <= 1'b1;
		end else begin
			event_stall <= 1'b0;
		end
	end

	// Outputs are read in the active region of the rising edge, before the
	// block's own registers update, so every field belongs to this transaction.
	always @(posedge clk) begin : check_events
		peak_event_t want;
		if (arst_n && event_valid && !event_stall) begin
			if (due_events.size() == 0) begin
				$display("%0t: event with nothing expected: time %0d channel %0d last %0b",
					$time, event_time, event_channel, last_of_run);
				failures++;
			end else begin
				want = due_events.pop_front();
				if (event_time !== want.t) begin
					$display("%0t: event_time expected %0d, actual %0d",
						$time, want.t, event_time);
					failures++;
				end
				if (event_channel !== want.ch) begin
					$display("%0t: event_channel expected %0d, actual %0d",
						$time, want.ch, event_channel);
					failures++;
				end
				if (last_of_run !== want.is_last) begin
					$display("%0t: last_of_run expected %0b, actual %0b",
						$time, want.is_last, last_of_run);
					failures++;
				end
				events_checked++;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
		$display("spike_peak_detector: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: margin of 24 means these early peaks are all discarded.
	task automatic test_reset_defaults();
		send_timepoint(lanes_of(0, 0, 5000, 0, 0, 0, 0, 0), 1'b0);
		send_timepoint(lanes_of(20000, 0, 0, 0, 0, -5000, 0, 0), 1'b1);
	endtask

	// All four polarity codes against full-scale and near-threshold samples.
	task automatic test_polarity_codes();
		for (int p = 0; p < 4; p++) begin
			configure(2'(p), 1'b1, 4'd8, 16'd100, 16'd0, 8'd1, RST_RECORD);
			send_timepoint(lanes_of(32767, -32768, 0, -1, 100, -100, 99, -99), 1'b1);
		end
	endtask

	// Threshold of zero makes a zero-sized peak that can only be pushed out;
	// the top threshold is only reached by negating the most negative code.
	task automatic test_threshold_extremes();
		configure(POL_KEEP, 1'b0, 4'd8, 16'd0, 16'd4, 8'd1, RST_RECORD);
		send_timepoint(lanes_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_timepoint(lanes_of(0, 0, 0, 500, 0, 0, 0, 0), 1'b0);
		send_timepoint(lanes_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
		configure(POL_NEGATE, 1'b1, 4'd8, 16'd32768, 16'd10, 8'd1, RST_RECORD);
		send_timepoint(lanes_of(-32768, 32767, -32767, 0, 0, 0, 0, 0), 1'b1);
	endtask

	// Replacement inside the window, a smaller value ignored, expiry, and the
	// narrowest and widest windows. Lanes outside the one in use carry noise.
	task automatic test_refractory_window();
		int lane0_seq [6];
		timepoint_t tp;
		lane0_seq = '{200, 300, 250, 0, 0, 0};
		configure(POL_KEEP, 1'b1, 4'd1, 16'd100, 16'd2, 8'd1, RST_RECORD);
		for (int i = 0; i < 6; i++) begin
			tp = random_timepoint();
			tp[0] = SAMPLE_BITS'(lane0_seq[i]);
			send_timepoint(tp, i == 5);
		end
		write_reg(REG_INTERVAL, CFG_DATA_BITS'(0));
		send_timepoint(lanes_of(500, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_timepoint(lanes_of(600, 0, 0, 0, 0, 0, 0, 0), 1'b1);
		write_reg(REG_INTERVAL, CFG_DATA_BITS'(16'hFFFF));
		send_timepoint(lanes_of(200, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_timepoint(lanes_of(300, 0, 0, 0, 0, 0, 0, 0), 1'b1);
	endtask

	// Lane counts above eight and of zero, peaks held in lanes that drop out
	// of use until the record ends, a clip of zero, and both record edges.
	task automatic test_lanes_and_edges();
		configure(POL_ABS, 1'b1, 4'd15, 16'd1000, 16'hFFFF, 8'd0, RST_RECORD);
		send_timepoint(lanes_of(2000, -2000, 2000, -2000, 2000, -2000, 2000, -2000), 1'b0);
		write_reg(REG_USED, CFG_DATA_BITS'(0));
		send_timepoint(lanes_of(3000, 3000, 3000, 3000, 3000, 3000, 3000, 3000), 1'b1);
		// Margin of one with a record of three: only the peak at index 1 fits.
		configure(POL_KEEP, 1'b0, 4'd1, 16'd1000, 16'd0, 8'd3, 32'd3);
		for (int i = 0; i < 4; i++)
			send_timepoint(lanes_of(5000, 0, 0, 0, 0, 0, 0, 0), i == 3);
		write_reg(REG_SPARE, '0);
	endtask

	task automatic random_config();
		int r;
		logic [USED_BITS-1:0]  lanes;
		logic [THR_BITS-1:0]   thr;
		logic [INT_BITS-1:0]   window;
		logic [CLIP_BITS-1:0]  clip;
		logic [REC_BITS-1:0]   rec;
		r = $urandom_range(0, 9);
		lanes = (r == 0) ? USED_BITS'($urandom_range(9, 15)) :
			(r == 1) ? '0 : USED_BITS'($urandom_range(1, 8));
		r = $urandom_range(0, 99);
		thr = (r < 70) ? THR_BITS'($urandom_range(200, 4000)) : (r < 80) ? '0 :
			(r < 88) ? 16'd32768 : THR_BITS'($urandom);
		r = $urandom_range(0, 99);
		window = (r < 60) ? INT_BITS'($urandom_range(1, 6)) : (r < 75) ? '0 :
			(r < 85) ? 16'hFFFF : INT_BITS'($urandom_range(7, 40));
		r = $urandom_range(0, 99);
		clip = (r < 65) ? CLIP_BITS'($urandom_range(1, 9)) : (r < 75) ? '0 :
			(r < 85) ? 8'd255 : CLIP_BITS'($urandom_range(10, 60));
		r = $urandom_range(0, 99);
		rec = (r < 50) ? RST_RECORD : (r < 75) ? REC_BITS'($urandom_range(6, 20)) :
			(r < 85) ? '0 : REC_BITS'($urandom);
		configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), lanes, thr, window,
			clip, rec);
	endtask

	// Phases of random settings, each feeding a few records of noisy spike
	// trains. Most records close with end of record; some run on into the next
	// one or are cut early. The idling pattern rotates between phases so that
	// each side spends stretches with and without gaps.
	task automatic test_random_records();
		int first_item;
		int phase;
		int len;
		bit closed;
		first_item  = timepoints_sent;
		phase = 0;
		while ((timepoints_sent - first_item) < RANDOM_ITEMS) begin
			tx_gaps   = (phase % 4 == 1) || (phase % 4 == 2);
			rx_stalls = (phase % 4 == 0) || (phase % 4 == 1);
			random_config();
			repeat ($urandom_range(1, 3)) begin
				// Now and then the sender holds off until the queue is empty.
				if ($urandom_range(0, 9) == 0)
					await_idle();
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
					$urandom_range(3, 12);
				closed = $urandom_range(0, 99) < 85;
				for (int i = 0; i < len; i++)
					send_timepoint(random_timepoint(),
						(closed && i == len - 1) || $urandom_range(0, 99) < 3);
			end
			phase++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_POLARITY;
		cfg_data      = '0;
		sample_valid  = 1'b0;
		sample_0      = '0;
		sample_1      = '0;
		sample_2      = '0;
		sample_3      = '0;
		sample_4      = '0;
		sample_5      = '0;
		sample_6      = '0;
		sample_7      = '0;
		end_of_record = 1'b0;
		reset_model();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		test_reset_defaults();
		test_polarity_codes();
		test_threshold_extremes();
		test_refractory_window();
		test_lanes_and_edges();
		test_random_records();
		await_idle();

		$display("Sent %0d timepoints in %0d records under %0d register settings; %0d events checked.",
			timepoints_sent, records_sent, settings_used, events_checked);
		$display("Both detector modes, all polarity codes, lane counts 0 to 15, window and edge extremes.");
		if (failures == 0)
			$display("spike_peak_detector: match");
		else
			$display("spike_peak_detector: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/spd_pkg.sv
rtl/spd_lane.sv
rtl/spd_merge.sv
rtl/spike_peak_detector.sv
verif/tb_spike_peak_detector.sv
